// ----- design/llt_pkg.sv -----
package llt_pkg;

  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 16;
  localparam int TIME_W  = 32;
  localparam int KEY_W   = 64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } llt_cmd_t;

  typedef struct packed {
    logic scan_last;
  } llt_stat_t;

endpackage

// ----- design/llt_ctrl.sv -----
module llt_ctrl import llt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  llt_stat_t stat_i,
  output logic      busy_o,
  output llt_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_last) state_nxt = S_LAST;
      end
      S_LAST:   state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy_o       = (state_r != S_IDLE);
  assign cmd_o.load   = (state_r == S_IDLE) && start;
  assign cmd_o.scan   = (state_r == S_SCAN);
  assign cmd_o.commit = (state_r == S_COMMIT);

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |=> !busy_o)
    else $error("controller still busy after commit");

  a_load_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> cmd_o.scan)
    else $error("accepted beat did not start a scan");

  a_last_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |=> cmd_o.commit)
    else $error("last compare not followed by commit");

endmodule

// ----- design/llt_datapath.sv -----
module llt_datapath import llt_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  llt_cmd_t           cmd_i,
  output llt_stat_t          stat_o,
  input  logic [1:0]         in_op,
  input  logic [KEY_W-1:0]   in_key_tag,
  input  logic [VALUE_W-1:0] in_new_value,
  input  logic [TIME_W-1:0]  in_now_time,
  output logic               out_valid,
  output logic               out_hit,
  output logic [VALUE_W-1:0] out_found_value,
  output logic [SLOT_W-1:0]  out_slot_used,
  output logic               out_evicted
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [TAG_BITS-1:0] tag_mem_r   [ENTRIES];
  logic [VALUE_W-1:0]  val_mem_r   [ENTRIES];
  logic [TIME_W-1:0]   stamp_mem_r [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;

  logic [1:0]          op_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [VALUE_W-1:0]  val_r;
  logic [TIME_W-1:0]   now_r;

  logic [IDX_W-1:0]    cnt_r;
  logic                cmp_en_r;
  logic [TAG_BITS-1:0] rd_tag_r;
  logic [VALUE_W-1:0]  rd_val_r;
  logic [TIME_W-1:0]   rd_stamp_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;

  logic                match_found_r, match_found_nxt;
  logic [IDX_W-1:0]    match_idx_r, match_idx_nxt;
  logic [VALUE_W-1:0]  match_val_r, match_val_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [TIME_W-1:0]   best_stamp_r, best_stamp_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;

  logic                out_valid_r, out_hit_r, out_evicted_r;
  logic [VALUE_W-1:0]  out_found_value_r;
  logic [SLOT_W-1:0]   out_slot_used_r;
  logic                hit_nxt, evicted_nxt;
  logic [VALUE_W-1:0]  found_value_nxt;
  logic [SLOT_W-1:0]   slot_used_nxt;

  logic [IDX_W-1:0]    victim;

  assign stat_o.scan_last = (cnt_r == IDX_W'(ENTRIES - 1));

  // Latch the item and read one entry per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r  <= in_op;
      tag_r <= in_key_tag[TAG_BITS-1:0];
      val_r <= in_new_value;
      now_r <= in_now_time;
    end
    if (cmd_i.scan) begin
      rd_tag_r   <= tag_mem_r[cnt_r];
      rd_val_r   <= val_mem_r[cnt_r];
      rd_stamp_r <= stamp_mem_r[cnt_r];
      rd_vld_r   <= valid_r[cnt_r];
      rd_idx_r   <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd_i.scan;
      if (cmd_i.load) begin
        cnt_r <= '0;
      end else if (cmd_i.scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Track lowest match, lowest free slot and oldest stamp below now.
  always_comb begin
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    match_val_nxt   = match_val_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    best_stamp_nxt  = best_stamp_r;
    pick_nxt        = pick_r;
    if (cmd_i.load) begin
      match_found_nxt = 1'b0;
      free_found_nxt  = 1'b0;
      best_stamp_nxt  = in_now_time;
      pick_nxt        = '0;
    end else if (cmp_en_r) begin
      if (rd_vld_r && (rd_tag_r == tag_r) && !match_found_r) begin
        match_found_nxt = 1'b1;
        match_idx_nxt   = rd_idx_r;
        match_val_nxt   = rd_val_r;
      end
      if (!rd_vld_r && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
      end
      if (rd_vld_r && (rd_stamp_r < best_stamp_r)) begin
        best_stamp_nxt = rd_stamp_r;
        pick_nxt       = rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r  <= match_idx_nxt;
    match_val_r  <= match_val_nxt;
    free_idx_r   <= free_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    pick_r       <= pick_nxt;
  end

  assign victim = free_found_r ? free_idx_r : pick_r;

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      case (op_r)
        OP_ADD: begin
          tag_mem_r[victim]   <= tag_r;
          val_mem_r[victim]   <= val_r;
          stamp_mem_r[victim] <= now_r;
        end
        OP_LOOKUP: begin
          if (match_found_r) stamp_mem_r[match_idx_r] <= now_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd_i.commit) begin
      case (op_r)
        OP_ADD:   valid_r[victim] <= 1'b1;
        OP_INVAL: begin
          if (match_found_r) valid_r[match_idx_r] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hit_nxt         = 1'b0;
    found_value_nxt = '0;
    slot_used_nxt   = '0;
    evicted_nxt     = 1'b0;
    case (op_r)
      OP_LOOKUP: begin
        if (match_found_r) begin
          hit_nxt         = 1'b1;
          found_value_nxt = match_val_r;
          slot_used_nxt   = SLOT_W'(match_idx_r);
        end
      end
      OP_ADD: begin
        slot_used_nxt = SLOT_W'(victim);
        evicted_nxt   = !free_found_r;
      end
      OP_INVAL: begin
        if (match_found_r) begin
          hit_nxt       = 1'b1;
          slot_used_nxt = SLOT_W'(match_idx_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_hit_r         <= hit_nxt;
      out_found_value_r <= found_value_nxt;
      out_slot_used_r   <= slot_used_nxt;
      out_evicted_r     <= evicted_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_found_value_r;
  assign out_slot_used   = out_slot_used_r;
  assign out_evicted     = out_evicted_r;

  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd_i.commit))
    else $error("result beat without a commit");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("result marks both hit and eviction");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.commit && (op_r == OP_ADD)) |=> valid_r[$past(victim)])
    else $error("add left its slot invalid");

endmodule

// ----- design/lru_lookup_table.sv -----
// Fully associative lookup table with least-recently-used replacement.
// Input channel: an operation (lookup, add, invalidate) with a key tag, a
// value for adds and the current time is accepted on a rising edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: one result beat per accepted item, shown on the out_
// ports for exactly one cycle while out_valid is high. The receiver cannot
// stall; the beat is gone after that cycle.
// Steps: the scan reads one entry of the tag, value and stamp memories per
// cycle through a single read port, then the last entry is compared, then
// the write-back is done and the result is registered. A new item may be
// started in the cycle the result is shown; none is taken while busy.
// Reset (rst_n low, synchronous) clears all valid flags at once; tags,
// values and stamps are not cleared and are never used before written.
// Lookup and invalidate act on the lowest valid matching entry. Add takes
// the lowest empty entry, else the oldest stamp below now, else entry 0.
module lru_lookup_table import llt_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [KEY_W-1:0]   in_key_tag,
  input  logic [VALUE_W-1:0] in_new_value,
  input  logic [TIME_W-1:0]  in_now_time,
  output logic               out_valid,
  output logic               out_hit,
  output logic [VALUE_W-1:0] out_found_value,
  output logic [SLOT_W-1:0]  out_slot_used,
  output logic               out_evicted
);

  llt_cmd_t  cmd;
  llt_stat_t stat;

  llt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  llt_datapath #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_op           (in_op),
    .in_key_tag      (in_key_tag),
    .in_new_value    (in_new_value),
    .in_now_time     (in_now_time),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_slot_used   (out_slot_used),
    .out_evicted     (out_evicted)
  );

endmodule
